[hw/rtl/tams_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tams_pkg;

    // field widths
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned CMD_W  = 17;
    localparam int unsigned STEP_W = 4;
    localparam int unsigned MODE_W = 3;

    // stream word widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned S_USER_W = 8;
    localparam int unsigned M_DATA_W = 24;

    // time base
    localparam int unsigned TICKS_PER_SECOND = 32768;
    localparam int unsigned MS_PER_SECOND    = 1000;

    // event codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FOLD   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_UNFOLD = 3'd4;

    // sequencer modes
    localparam logic [MODE_W-1:0] MODE_STOPPED  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STARTREQ = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STARTED  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOPREQ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FOLD     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNFOLD   = 3'd5;

    localparam logic [CMD_W-1:0] LIGHT_BIT = 17'h10000;

    // sequence lengths
    localparam int unsigned MAIN_LEN   = 14;
    localparam int unsigned FOLD_LEN   = 5;
    localparam int unsigned UNFOLD_LEN = 4;

    localparam int unsigned MAIN_IDX_W   = $clog2(MAIN_LEN);
    localparam int unsigned FOLD_IDX_W   = $clog2(FOLD_LEN);
    localparam int unsigned UNFOLD_IDX_W = $clog2(UNFOLD_LEN);

    // milliseconds to ticks, only ever called on constants
    function automatic logic [TIME_W-1:0] ms_to_ticks(input logic [TIME_W-1:0] ms);
        return (ms * TIME_W'(TICKS_PER_SECOND)) / TIME_W'(MS_PER_SECOND);
    endfunction

    // main sequence
    localparam logic [CMD_W-1:0] MAIN_CMD [MAIN_LEN] = '{
        17'h000, 17'h001, 17'h004, 17'h1A4, 17'h100, 17'h002, 17'h000,
        17'h001, 17'h200, 17'h058, 17'h040, 17'h010, 17'h008, 17'h002
    };
    localparam logic [TIME_W-1:0] MAIN_TICKS [MAIN_LEN] = '{
        ms_to_ticks(64'd1000), ms_to_ticks(64'd1400), ms_to_ticks(64'd2500),
        ms_to_ticks(64'd1600), ms_to_ticks(64'd3000), ms_to_ticks(64'd1400),
        ms_to_ticks(64'd1000), ms_to_ticks(64'd1400), ms_to_ticks(64'd4400),
        ms_to_ticks(64'd1600), ms_to_ticks(64'd175),  ms_to_ticks(64'd100),
        ms_to_ticks(64'd2300), ms_to_ticks(64'd1200)
    };

    // fold sequence
    localparam logic [CMD_W-1:0] FOLD_CMD [FOLD_LEN] = '{
        17'h000, 17'h002, 17'h068, 17'h020, 17'h040
    };
    localparam logic [TIME_W-1:0] FOLD_TICKS [FOLD_LEN] = '{
        ms_to_ticks(64'd0), ms_to_ticks(64'd100), ms_to_ticks(64'd4500),
        ms_to_ticks(64'd200), ms_to_ticks(64'd800)
    };

    // unfold sequence
    localparam logic [CMD_W-1:0] UNFOLD_CMD [UNFOLD_LEN] = '{
        17'h000, 17'h010, 17'h080, 17'h094
    };
    localparam logic [TIME_W-1:0] UNFOLD_TICKS [UNFOLD_LEN] = '{
        ms_to_ticks(64'd0), ms_to_ticks(64'd200), ms_to_ticks(64'd850),
        ms_to_ticks(64'd4500)
    };

    // held event between input register and core
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now_ticks;
    } tams_event_t;

    // result from core to output register
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] motor_command;
    } tams_result_t;

    // sequencer state seen by the top level
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] step_index;
    } tams_status_t;

endpackage

`default_nettype wire

[hw/rtl/tams_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module tams_in_stage
    import tams_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // now_ticks[63:0]
    input  wire logic [S_USER_W-1:0] s_tuser,   // func[2:0], zero pad[7:3]
    input  wire logic                take,
    output tams_event_t              evt
);

    logic              valid_reg;
    logic              valid_next;
    logic [FUNC_W-1:0] func_reg;
    logic [TIME_W-1:0] now_reg;
    logic              accept;

    // ready when the register is empty or the held word leaves this cycle
    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser[FUNC_W-1:0];
            now_reg  <= s_tdata[TIME_W-1:0];
        end
    end

    assign evt.valid     = valid_reg;
    assign evt.func      = func_reg;
    assign evt.now_ticks = now_reg;

endmodule

`default_nettype wire

[hw/rtl/tams_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module tams_core
    import tams_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  tams_event_t       evt,
    input  wire logic         fire,
    output tams_result_t      res,
    output tams_status_t      status
);

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;

    logic [STEP_W-1:0] seq_len;
    logic [STEP_W-1:0] step_inc;
    logic [STEP_W-1:0] step_adv;
    logic [CMD_W-1:0]  sel_cmd;
    logic [TIME_W-1:0] sel_ticks;
    logic [TIME_W-1:0] deadline_adv;
    logic              late;
    logic [CMD_W-1:0]  main_out;

    // length of the sequence being played
    always_comb
    begin
        case (mode_reg)
            MODE_FOLD:   seq_len = STEP_W'(FOLD_LEN);
            MODE_UNFOLD: seq_len = STEP_W'(UNFOLD_LEN);
            default:     seq_len = STEP_W'(MAIN_LEN);
        endcase
    end

    // next step with wrap at the sequence end
    assign step_inc = step_reg + 1'b1;
    assign step_adv = (step_inc >= seq_len) ? '0 : step_inc;

    // rom lookup of the next step
    always_comb
    begin
        case (mode_reg)
            MODE_FOLD:
            begin
                sel_cmd   = FOLD_CMD[step_adv[FOLD_IDX_W-1:0]];
                sel_ticks = FOLD_TICKS[step_adv[FOLD_IDX_W-1:0]];
            end
            MODE_UNFOLD:
            begin
                sel_cmd   = UNFOLD_CMD[step_adv[UNFOLD_IDX_W-1:0]];
                sel_ticks = UNFOLD_TICKS[step_adv[UNFOLD_IDX_W-1:0]];
            end
            default:
            begin
                sel_cmd   = MAIN_CMD[step_adv[MAIN_IDX_W-1:0]];
                sel_ticks = MAIN_TICKS[step_adv[MAIN_IDX_W-1:0]];
            end
        endcase
    end

    assign late         = evt.now_ticks > deadline_reg;
    assign deadline_adv = evt.now_ticks + sel_ticks;

    // light on while running, off while winding down
    assign main_out = (mode_reg == MODE_STOPREQ) ? (sel_cmd & ~LIGHT_BIT)
                                                 : (sel_cmd | LIGHT_BIT);

    // event handling
    always_comb
    begin
        mode_next         = mode_reg;
        step_next         = step_reg;
        deadline_next     = deadline_reg;
        res.valid         = 1'b0;
        res.motor_command = '0;
        if (fire)
        begin
            case (evt.func)
                FUNC_START:
                begin
                    if (mode_reg == MODE_STOPPED)
                    begin
                        mode_next = MODE_STARTREQ;
                    end
                end
                FUNC_STOP:
                begin
                    if (mode_reg == MODE_STARTED)
                    begin
                        mode_next = MODE_STOPREQ;
                    end
                end
                FUNC_FOLD, FUNC_UNFOLD:
                begin
                    if (mode_reg == MODE_STOPPED)
                    begin
                        mode_next     = (evt.func == FUNC_FOLD) ? MODE_FOLD : MODE_UNFOLD;
                        step_next     = '0;
                        deadline_next = '0;
                    end
                end
                FUNC_TICK:
                begin
                    case (mode_reg)
                        MODE_STARTREQ:
                        begin
                            mode_next     = MODE_STARTED;
                            step_next     = '0;
                            deadline_next = '0;
                        end
                        MODE_STARTED, MODE_STOPREQ:
                        begin
                            if (late)
                            begin
                                step_next         = step_adv;
                                deadline_next     = deadline_adv;
                                res.valid         = 1'b1;
                                res.motor_command = main_out;
                            end
                            // pending stop completes at step zero
                            if ((mode_reg == MODE_STOPREQ) && (step_next == '0))
                            begin
                                mode_next = MODE_STOPPED;
                            end
                        end
                        MODE_FOLD, MODE_UNFOLD:
                        begin
                            if (late)
                            begin
                                step_next         = step_adv;
                                deadline_next     = deadline_adv;
                                res.valid         = 1'b1;
                                res.motor_command = sel_cmd;
                                if (step_adv == '0)
                                begin
                                    mode_next = MODE_STOPPED;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STOPPED;
            step_reg     <= '1;
            deadline_reg <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            step_reg     <= step_next;
            deadline_reg <= deadline_next;
        end
    end

    assign status.mode       = mode_reg;
    assign status.step_index = step_reg;

endmodule

`default_nettype wire

[hw/rtl/tams_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module tams_out_stage
    import tams_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  tams_result_t             res,
    output logic                     room,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // motor_command[16:0], zero pad[23:17]
);

    logic             valid_reg;
    logic             valid_next;
    logic [CMD_W-1:0] cmd_reg;

    // a new result may land when the register is empty or drains now
    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            cmd_reg <= res.motor_command;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_DATA_W - CMD_W)'(0), cmd_reg};

endmodule

`default_nettype wire

[hw/rtl/timed_arm_motion_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Timed arm motion sequencer. Each input word is one event: a tick carrying the
// current time in s_tdata, or a start, stop, fold or unfold request, with the event
// code in s_tuser. On a tick past the current deadline, while a table is playing,
// the block steps through one of three fixed motion tables and sends that step's
// motor mask on the master side; all other events send nothing. Throughput is one
// word per clock while the result register drains: the event sits in an input
// register; the table lookup, 64-bit deadline compare and add are combinational
// between it and the state and result registers, from which the word leaves on the
// master side. The only stall is a full result register that the consumer does not
// take, which holds the input register and drops s_tready.
module timed_arm_motion_sequencer
    import tams_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // now_ticks[63:0]
    input  wire logic [S_USER_W-1:0] s_tuser,   // func[2:0], zero pad[7:3]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // motor_command[16:0], zero pad[23:17]
);

    tams_event_t  evt;
    tams_result_t res;
    tams_status_t status;
    logic         room;
    logic         fire;

    // core consumes the held word when the result register has room
    assign fire = evt.valid && room;

    tams_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (fire),
        .evt      (evt)
    );

    tams_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .fire   (fire),
        .res    (res),
        .status (status)
    );

    tams_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a stalled result must never be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !fire)
    else $error("core fired while result register stalled");

    // results come only from a playing sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (status.mode == MODE_STARTED || status.mode == MODE_STOPREQ ||
                       status.mode == MODE_FOLD || status.mode == MODE_UNFOLD))
    else $error("result produced outside a playing mode");

    // step index stays inside the table being played
    assert property (@(posedge clk) disable iff (!rst_n)
        ((status.mode == MODE_FOLD) |-> (status.step_index < STEP_W'(FOLD_LEN))) and
        ((status.mode == MODE_UNFOLD) |-> (status.step_index < STEP_W'(UNFOLD_LEN))) and
        ((status.mode == MODE_STARTED) |-> (status.step_index < STEP_W'(MAIN_LEN))))
    else $error("step index beyond table length");

    // an event accepted into a full input register needs the old one consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && evt.valid) |-> fire)
    else $error("input register overwritten");

endmodule

`default_nettype wire

[test/timed_arm_motion_sequencer_check.sv]
`timescale 1ns / 1ps

module timed_arm_motion_sequencer_check
    import tams_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // now_ticks[63:0]
    input  logic [S_USER_W-1:0] s_tuser,     // func[2:0], zero pad[7:3]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,     // motor_command[16:0], zero pad[23:17]
    output int unsigned         mismatches,
    output int unsigned         awaiting
);

    // motion tables: motor masks and step durations in milliseconds
    localparam logic [CMD_W-1:0] ARM_MAIN_MASK [MAIN_LEN] = '{
        17'h000, 17'h001, 17'h004, 17'h1A4, 17'h100, 17'h002, 17'h000,
        17'h001, 17'h200, 17'h058, 17'h040, 17'h010, 17'h008, 17'h002
    };
    localparam int unsigned ARM_MAIN_MS [MAIN_LEN] = '{
        1000, 1400, 2500, 1600, 3000, 1400, 1000,
        1400, 4400, 1600, 175, 100, 2300, 1200
    };
    localparam logic [CMD_W-1:0] ARM_FOLD_MASK [FOLD_LEN] = '{
        17'h000, 17'h002, 17'h068, 17'h020, 17'h040
    };
    localparam int unsigned ARM_FOLD_MS [FOLD_LEN] = '{0, 100, 4500, 200, 800};
    localparam logic [CMD_W-1:0] ARM_UNFOLD_MASK [UNFOLD_LEN] = '{
        17'h000, 17'h010, 17'h080, 17'h094
    };
    localparam int unsigned ARM_UNFOLD_MS [UNFOLD_LEN] = '{0, 200, 850, 4500};

    // predicted sequencer state
    logic [MODE_W-1:0] seq_mode;
    logic [STEP_W-1:0] seq_step;
    logic [TIME_W-1:0] seq_deadline;
    logic [CMD_W-1:0]  cmd_expected [$];
    int unsigned       fail_total = 0;

    // move to the next step of the chosen table and rearm the deadline
    task automatic advance_step(input logic [MODE_W-1:0] which,
                                input logic [TIME_W-1:0] now,
                                output logic [CMD_W-1:0] cmd);
        int unsigned       len;
        int unsigned       ms;
        logic [STEP_W-1:0] nxt;
        case (which)
            MODE_FOLD:   len = FOLD_LEN;
            MODE_UNFOLD: len = UNFOLD_LEN;
            default:     len = MAIN_LEN;
        endcase
        nxt = seq_step + 1'b1;
        if (nxt >= len)
            nxt = '0;
        case (which)
            MODE_FOLD:
            begin
                cmd = ARM_FOLD_MASK[nxt];
                ms  = ARM_FOLD_MS[nxt];
            end
            MODE_UNFOLD:
            begin
                cmd = ARM_UNFOLD_MASK[nxt];
                ms  = ARM_UNFOLD_MS[nxt];
            end
            default:
            begin
                cmd = ARM_MAIN_MASK[nxt];
                ms  = ARM_MAIN_MS[nxt];
            end
        endcase
        seq_step     = nxt;
        seq_deadline = now + (TIME_W'(ms) * TIME_W'(TICKS_PER_SECOND)) /
                       TIME_W'(MS_PER_SECOND);
    endtask

    // apply one accepted event, queue the motor word it causes
    task automatic arm_event(input logic [FUNC_W-1:0] func,
                             input logic [TIME_W-1:0] now);
        logic [CMD_W-1:0] cmd;
        case (func)
            FUNC_START:
                if (seq_mode == MODE_STOPPED)
                    seq_mode = MODE_STARTREQ;
            FUNC_STOP:
                if (seq_mode == MODE_STARTED)
                    seq_mode = MODE_STOPREQ;
            FUNC_FOLD, FUNC_UNFOLD:
                if (seq_mode == MODE_STOPPED)
                begin
                    seq_mode     = (func == FUNC_FOLD) ? MODE_FOLD : MODE_UNFOLD;
                    seq_step     = '0;
                    seq_deadline = '0;
                end
            FUNC_TICK:
                case (seq_mode)
                    MODE_STARTREQ:
                    begin
                        seq_step     = '0;
                        seq_deadline = '0;
                        seq_mode     = MODE_STARTED;
                    end
                    MODE_STARTED, MODE_STOPREQ:
                    begin
                        if (now > seq_deadline)
                        begin
                            advance_step(MODE_STARTED, now, cmd);
                            // light stays on only while running
                            if (seq_mode == MODE_STOPREQ)
                                cmd = cmd & ~LIGHT_BIT;
                            else
                                cmd = cmd | LIGHT_BIT;
                            cmd_expected.push_back(cmd);
                        end
                        // a pending stop lands once the sequence is back at step zero
                        if (seq_mode == MODE_STOPREQ && seq_step == '0)
                            seq_mode = MODE_STOPPED;
                    end
                    MODE_FOLD, MODE_UNFOLD:
                        if (now > seq_deadline)
                        begin
                            advance_step(seq_mode, now, cmd);
                            if (seq_step == '0)
                                seq_mode = MODE_STOPPED;
                            cmd_expected.push_back(cmd);
                        end
                    default: ;
                endcase
            default: ;
        endcase
    endtask

    // compare each motor word, then predict from each accepted event word
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [CMD_W-1:0] want;
        if (!rst_n)
        begin
            seq_mode     = MODE_STOPPED;
            seq_step     = '1;
            seq_deadline = '0;
            cmd_expected.delete();
            awaiting <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cmd_expected.size() == 0)
                begin
                    $display("%0t: motor_command expected none, got %05h",
                             $time, m_tdata[CMD_W-1:0]);
                    fail_total++;
                end
                else
                begin
                    want = cmd_expected.pop_front();
                    if (m_tdata[CMD_W-1:0] !== want)
                    begin
                        $display("%0t: motor_command expected %05h, got %05h",
                                 $time, want, m_tdata[CMD_W-1:0]);
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                arm_event(s_tuser[FUNC_W-1:0], s_tdata);
            awaiting <= cmd_expected.size();
        end
        mismatches <= fail_total;
    end

endmodule

[test/timed_arm_motion_sequencer_test.sv]
`timescale 1ns / 1ps

module timed_arm_motion_sequencer_test;
    import tams_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // now_ticks[63:0]
    logic [S_USER_W-1:0] s_tuser;    // func[2:0], zero pad[7:3]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // motor_command[16:0], zero pad[23:17]

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    timed_arm_motion_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    timed_arm_motion_sequencer_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL timed_arm_motion_sequencer");
            $finish;
        end
    end

    // motor side: random stalls, one long hold-off, one stretch always ready
    initial
    begin : motor_sink
        int unsigned hold_left;
        bit          held;
        m_tready  = 1'b0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!held && items_sent >= 300)
            begin
                held      = 1'b1;
                hold_left = 200;
                m_tready <= 1'b0;
            end
            else if (items_sent >= 500 && items_sent < 700)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 9);
        end
    end

    // offer one event word and hold it until taken
    task automatic offer(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= S_USER_W'(func);
        s_tdata  <= now;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // offer, then maybe leave a one-cycle gap
    task automatic send_event(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] now);
        offer(func, now);
        if ((items_sent < 500 || items_sent >= 700) && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin : event_source
        logic [TIME_W-1:0] t_now;
        logic [TIME_W-1:0] t_tick;
        logic [TIME_W-1:0] jump;
        logic [FUNC_W-1:0] func;
        int unsigned       pick;
        int unsigned       sel;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stopped: ticks, unused codes and stop do nothing
        send_event(FUNC_TICK, 64'd5);
        send_event(3'd5, '1);
        send_event(3'd7, 64'h5555_5555_5555_5555);
        send_event(FUNC_STOP, '0);

        // fold pass, unfold ignored meanwhile, deadline must be strictly passed
        send_event(FUNC_FOLD, '0);
        send_event(FUNC_UNFOLD, '0);
        send_event(FUNC_TICK, 64'd1);
        send_event(FUNC_TICK, 64'd3277);
        send_event(FUNC_TICK, 64'd3278);
        t_now = 64'd3278;
        repeat (3)
        begin
            t_now = t_now + 64'd1_000_000;
            send_event(FUNC_TICK, t_now);
        end

        // unfold pass
        send_event(FUNC_UNFOLD, '0);
        repeat (4)
        begin
            t_now = t_now + 64'd1_000_000;
            send_event(FUNC_TICK, t_now);
        end

        // start, stop at step zero with no advance
        send_event(FUNC_START, '0);
        send_event(FUNC_START, '0);
        send_event(FUNC_FOLD, '0);
        send_event(FUNC_TICK, '0);
        send_event(FUNC_STOP, '0);
        send_event(FUNC_TICK, '0);

        // start at the top of time, deadline wraps past zero
        send_event(FUNC_START, '0);
        send_event(FUNC_TICK, '1);
        send_event(FUNC_TICK, '1);
        send_event(FUNC_TICK, '0);
        t_now = '0;

        // random events, mostly ticks moving time forward
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick   = $urandom_range(99);
            t_tick = {$urandom, $urandom};
            if (pick < 70)
            begin
                func = FUNC_TICK;
                sel  = $urandom_range(19);
                if (sel < 8)
                    t_now = t_now + $urandom_range(0, 8000);
                else if (sel < 16)
                    t_now = t_now + $urandom_range(0, 160000);
                if (sel == 17)
                    // slightly in the past, time itself does not move
                    t_tick = (t_now > 64'd5000) ? t_now - $urandom_range(0, 5000) : t_now;
                else if (sel == 18)
                begin
                    jump = {$urandom, $urandom} >> $urandom_range(0, 63);
                    if (t_now > ~jump)
                    begin
                        t_tick = '1;
                        t_now  = '0;
                    end
                    else
                    begin
                        t_now  = t_now + jump;
                        t_tick = t_now;
                    end
                end
                else if (sel == 19)
                begin
                    t_tick = '1;
                    t_now  = '0;
                end
                else
                    t_tick = t_now;
            end
            else if (pick < 80)
                func = FUNC_START;
            else if (pick < 86)
                func = FUNC_STOP;
            else if (pick < 92)
                func = FUNC_FOLD;
            else if (pick < 98)
                func = FUNC_UNFOLD;
            else
                func = FUNC_W'($urandom_range(5, 7));
            send_event(func, t_tick);

            // let the block drain completely once
            if (n == 800)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (awaiting != 0)
                    @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the input and result registers
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS timed_arm_motion_sequencer");
        else
            $display("FAIL timed_arm_motion_sequencer");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tams_pkg.sv
hw/rtl/tams_in_stage.sv
hw/rtl/tams_core.sv
hw/rtl/tams_out_stage.sv
hw/rtl/timed_arm_motion_sequencer.sv
test/timed_arm_motion_sequencer_check.sv
test/timed_arm_motion_sequencer_test.sv
